>>> rtl/core/fod_power_loss_detector_core_assert.svh
`ifndef FOD_POWER_LOSS_DETECTOR_CORE_ASSERT_SVH
`define FOD_POWER_LOSS_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FODPL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fodpl assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define FODPL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fodpl assertion failed");

`endif

>>> rtl/core/fodpl_pkg.sv
package fodpl_pkg;

	localparam int TICK_WIDTH = 16;

	// Divide by 1000: the dividend stays below 65536000, and a reciprocal scaled by 2**36
	// gives the exact quotient for every dividend below 2**26.
	localparam int DIVIDEND_W  = 26;
	localparam int QUOT_W      = 16;
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 36;

	localparam logic [15:0]        MW_DIVISOR = 16'd1000;
	localparam logic [RECIP_W-1:0] MW_RECIP   = 27'd68719477;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> rtl/core/fodpl_div.sv
// Division by a constant: the dividend is registered, then multiplied by the scaled reciprocal.
module fodpl_div import fodpl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	output div_status_t           status,
	output logic [QUOT_W-1:0]     quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [DIVIDEND_W-1:0]         num_q;
	logic [QUOT_W-1:0]             quo_q;
	logic [DIVIDEND_W+RECIP_W-1:0] prod;

	assign prod = num_q * MW_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
		end else if (busy_q) begin
			quo_q <= prod[RECIP_SHIFT +: QUOT_W];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

>>> rtl/core/fod_power_loss_detector_core.sv
// Channel   Direction  Handshake             Payload
// request   in         req_valid / req_stall command, tick_time, voltage_mv, current_ma,
//                                            rx_power_packet, ping_current, in_power_transfer
// result    out        res_valid / res_stall window_done, object_detected, power_loss
// config    in         cfg_we                cfg_index, cfg_data
//
// One request is worked on at a time; req_stall is high until its result is registered.
// Check, clear and in-window samples go straight to the final state; a start runs the
// shared 16x16 multiplier three times in a row, then forms the estimate.
// A sample that closes the window goes through the divider, which multiplies by the
// reciprocal of 1000; a saturated loss skips it. Reset clears sequencer and configuration
// at once; a stalled result holds the sequencer in its final state.
`include "fod_power_loss_detector_core_assert.svh"

module fod_power_loss_detector_core import fodpl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [1:0]            command,
	input  logic [TICK_WIDTH-1:0] tick_time,
	input  logic [15:0]           voltage_mv,
	input  logic [15:0]           current_ma,
	input  logic [7:0]            rx_power_packet,
	input  logic [15:0]           ping_current,
	input  logic                  in_power_transfer,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  window_done,
	output logic                  object_detected,
	output logic [15:0]           power_loss,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_FOD_ENABLE     = 3'd0,
		REG_LOSS_THRESHOLD = 3'd1,
		REG_PING_THRESHOLD = 3'd2,
		REG_HIT_LIMIT      = 3'd3,
		REG_WINDOW_TICKS   = 3'd4,
		REG_RX_MAX_POWER   = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_VI,
		S_MUL_PKT,
		S_MUL_SCALE,
		S_EST,
		S_MUL_EST,
		S_SUB,
		S_DIV,
		S_FIN
	} state_t;

	// Transmit power thresholds expressed on the raw V*I product.
	localparam logic [31:0] TX_LOW_PROD   = 32'd2500000;
	localparam logic [31:0] TX_HIGH_PROD  = 32'd6250000;
	localparam logic [31:0] LOSS_SAT_PROD = 32'd65536000;
	localparam logic [15:0] OFFSET_LOW    = 16'd355;
	localparam logic [15:0] OFFSET_HIGH   = 16'd4200;
	localparam logic [15:0] RX_SCALE      = 16'd125;
	localparam int          RX_SHIFT      = 4;
	localparam logic [7:0]  WINDOW_DFLT   = 8'd10;

	// Configuration registers.
	logic        fod_enable_q;
	logic [15:0] loss_threshold_q;
	logic [15:0] ping_threshold_q;
	logic [7:0]  hit_limit_q;
	logic [7:0]  window_ticks_q;
	logic [7:0]  rx_max_power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fod_enable_q     <= 1'b0;
			loss_threshold_q <= 16'd700;
			ping_threshold_q <= 16'd0;
			hit_limit_q      <= 8'd3;
			window_ticks_q   <= 8'd0;
			rx_max_power_q   <= 8'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOD_ENABLE:     fod_enable_q     <= cfg_data[0];
				REG_LOSS_THRESHOLD: loss_threshold_q <= cfg_data;
				REG_PING_THRESHOLD: ping_threshold_q <= cfg_data;
				REG_HIT_LIMIT:      hit_limit_q      <= cfg_data[7:0];
				REG_WINDOW_TICKS:   window_ticks_q   <= cfg_data[7:0];
				REG_RX_MAX_POWER:   rx_max_power_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	state_t                state_q;
	logic                  win_active_q;
	logic [TICK_WIDTH-1:0] win_start_q;
	logic [15:0]           last_v_q;
	logic [15:0]           last_i_q;
	logic [15:0]           est_q;
	logic [15:0]           offset_q;
	logic [15:0]           loss_q;
	logic [7:0]            hit_q;
	logic                  det_q;
	logic                  item_done_q;
	logic                  item_det_q;
	logic                  res_valid_q;
	logic                  window_done_q;
	logic                  object_detected_q;
	logic [15:0]           power_loss_q;
	logic                  is_start_q;
	logic [7:0]            pkt_q;
	logic [31:0]           p_q;
	logic [31:0]           m_q;

	logic                  accept;
	logic [15:0]           mul_a;
	logic [15:0]           mul_b;
	logic [31:0]           mul_p;
	logic [7:0]            win_len;
	logic [TICK_WIDTH-1:0] elapsed;
	logic                  in_window;
	logic [15:0]           chk_val;
	logic [15:0]           chk_thr;
	logic [7:0]            hit_inc;
	logic [19:0]           est_sum;
	logic                  sub_ge;
	logic [31:0]           sub_diff;
	logic                  loss_sat;
	logic                  div_start;
	div_status_t           div_st;
	logic [QUOT_W-1:0]     div_quo;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);

	// The one multiplier of the sequencer, shared by every product it needs outside the divider.
	always_comb begin
		unique case (state_q)
			S_MUL_VI: begin
				mul_a = last_v_q;
				mul_b = last_i_q;
			end
			S_MUL_PKT: begin
				mul_a = {8'd0, pkt_q};
				mul_b = {8'd0, rx_max_power_q};
			end
			S_MUL_SCALE: begin
				mul_a = m_q[15:0];
				mul_b = RX_SCALE;
			end
			S_MUL_EST: begin
				mul_a = est_q;
				mul_b = MW_DIVISOR;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign win_len   = (window_ticks_q == 8'd0) ? WINDOW_DFLT : window_ticks_q;
	assign elapsed   = tick_time - win_start_q;
	assign in_window = elapsed <= TICK_WIDTH'(win_len);

	assign chk_val = in_power_transfer ? loss_q : ping_current;
	assign chk_thr = in_power_transfer ? loss_threshold_q : ping_threshold_q;
	assign hit_inc = hit_q + 8'd1;

	// packet*max*1000/128 is packet*max*125/16, so the scaled product only shifts.
	assign est_sum = {1'b0, m_q[RX_SHIFT+18:RX_SHIFT]} + {4'd0, offset_q};

	// floor(P/1000) - est equals floor((P - est*1000)/1000) whenever it is positive.
	assign sub_ge    = p_q >= m_q;
	assign sub_diff  = p_q - m_q;
	assign loss_sat  = sub_ge && (sub_diff >= LOSS_SAT_PROD);
	assign div_start = (state_q == S_SUB) && !loss_sat;

	fodpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sub_ge ? sub_diff[DIVIDEND_W-1:0] : '0),
		.status   (div_st),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			win_active_q <= 1'b0;
			win_start_q  <= '0;
			last_v_q     <= '0;
			last_i_q     <= '0;
			est_q        <= '0;
			offset_q     <= '0;
			loss_q       <= '0;
			hit_q        <= '0;
			det_q        <= 1'b0;
			item_done_q  <= 1'b0;
			item_det_q   <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_done_q <= 1'b0;
						item_det_q  <= 1'b0;
						state_q     <= S_FIN;
						unique case (cmd_t'(command))
							CMD_START: begin
								win_start_q  <= tick_time;
								last_v_q     <= voltage_mv;
								last_i_q     <= current_ma;
								win_active_q <= 1'b1;
								state_q      <= S_MUL_VI;
							end
							CMD_SAMPLE: begin
								if (win_active_q) begin
									if (in_window) begin
										last_v_q <= voltage_mv;
										last_i_q <= current_ma;
									end else begin
										win_active_q <= 1'b0;
										win_start_q  <= tick_time;
										item_done_q  <= 1'b1;
										state_q      <= S_MUL_VI;
									end
								end
							end
							CMD_CHECK: begin
								if (fod_enable_q) begin
									if ((chk_val > chk_thr) && !det_q) begin
										if (hit_inc >= hit_limit_q) begin
											det_q      <= 1'b1;
											hit_q      <= '0;
											item_det_q <= 1'b1;
										end else begin
											hit_q      <= hit_inc;
											item_det_q <= det_q;
										end
									end else begin
										hit_q      <= '0;
										item_det_q <= det_q;
									end
								end
							end
							CMD_CLEAR: begin
								hit_q <= '0;
								det_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_MUL_VI: begin
					state_q <= is_start_q ? S_MUL_PKT : S_MUL_EST;
				end
				S_MUL_PKT: begin
					// Between the two thresholds the previous offset stays.
					if (p_q < TX_LOW_PROD) begin
						offset_q <= OFFSET_LOW;
					end else if (p_q >= TX_HIGH_PROD) begin
						offset_q <= OFFSET_HIGH;
					end
					state_q <= S_MUL_SCALE;
				end
				S_MUL_SCALE: begin
					state_q <= S_EST;
				end
				S_EST: begin
					est_q   <= (est_sum > 20'hFFFF) ? 16'hFFFF : est_sum[15:0];
					state_q <= S_FIN;
				end
				S_MUL_EST: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					if (loss_sat) begin
						loss_q  <= 16'hFFFF;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						loss_q  <= div_quo;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operands, products and the result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			is_start_q <= (cmd_t'(command) == CMD_START);
			pkt_q      <= rx_power_packet;
		end
		if (state_q == S_MUL_VI) begin
			p_q <= mul_p;
		end
		if ((state_q == S_MUL_PKT) || (state_q == S_MUL_SCALE) || (state_q == S_MUL_EST)) begin
			m_q <= mul_p;
		end
		if ((state_q == S_FIN) && (!res_valid_q || !res_stall)) begin
			window_done_q     <= item_done_q;
			object_detected_q <= item_det_q;
			power_loss_q      <= loss_q;
		end
	end

	assign res_valid       = res_valid_q;
	assign window_done     = window_done_q;
	assign object_detected = object_detected_q;
	assign power_loss      = power_loss_q;

	`FODPL_ASSERT_NOW(a_div_done_in_div, div_st.done, state_q == S_DIV)
	`FODPL_ASSERT_NOW(a_close_clears_window, $rose(res_valid_q) && window_done_q, !win_active_q)
	`FODPL_ASSERT_NOW(a_result_from_fin, $rose(res_valid_q), $past(state_q == S_FIN))

endmodule
